[rtl/chc_pkg.sv]
// ----------------------------------------------------------------------------
// chc_pkg: shared types and constants for the canonical Huffman codec
// Sizes of the code tables, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package chc_pkg;

  // Table sizes
  localparam int MAX_CODE_LENGTH = 16;
  localparam int SYMBOL_CAPACITY = 256;
  localparam int ENC_DEPTH       = 256;

  // Derived widths
  localparam int LEN_IDX_W = $clog2(MAX_CODE_LENGTH);
  localparam int SYM_AW    = $clog2(SYMBOL_CAPACITY);
  localparam int ENC_AW    = $clog2(ENC_DEPTH);
  localparam int POS_W     = $clog2(MAX_CODE_LENGTH * 255 + 1);

  // Field and table widths
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 9;
  localparam int SYMBOL_W   = 8;
  localparam int CNT_VAL_W  = 8;
  localparam int LEN_W      = 5;
  localparam int CODE_W     = 16;
  localparam int TAB_W      = 24;
  localparam int OFFSET_W   = 9;
  localparam int OFFSET_MAX = 511;
  localparam int ENC_W      = CODE_W + LEN_W;

  // Result kinds
  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_COUNT  = 3'd0,
    OP_LOAD_SYMBOL = 3'd1,
    OP_BUILD       = 3'd2,
    OP_DECODE_BIT  = 3'd3,
    OP_END_STREAM  = 3'd4,
    OP_ENCODE      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_INDEX = 3'd1,
    STATUS_NO_CODE   = 3'd2,
    STATUS_END_DATA  = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLEN,
    ST_BSYM,
    ST_BWR,
    ST_DCMP,
    ST_EMIT
  } state_t;

  // Where the pending result takes its payload from
  typedef enum logic [1:0] {
    SRC_REG,
    SRC_SYM,
    SRC_ENC
  } src_t;

endpackage

[rtl/chc_ram.sv]
// ----------------------------------------------------------------------------
// chc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module chc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/canonical_huffman_codec.sv]
// ----------------------------------------------------------------------------
// canonical_huffman_codec: canonical JPEG Huffman table builder and codec
// Loads code counts and symbols, builds the canonical tables, then decodes a
// bit stream one bit per request or looks up the code of a symbol.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_stall with the operation and its fields;
//   results leave on res_valid/res_stall. symbol_count is written through
//   cfg_write_en/cfg_write_data; the user must do so only while the block is
//   idle, as the block does not enforce it. Per request: loads and unused
//   operations finish when taken; an encode reads the encode RAM, then
//   outputs; a decode bit does the table compare and, on a hit in the list,
//   the symbol RAM read, then outputs only when it gives a result. The result
//   register is valid in the cycle after the output step. A build makes one
//   pass per length (BLEN, BSYM) and a BSYM step per code; each placed symbol
//   is read through the symbol RAM's single read port, then written in BWR.
//   Reset clears the code tables, the encode valid bits, the pending decode
//   bits and symbol_count at once; there is no clearing pass. The symbol list
//   is not cleared and must be loaded before use.
//   When the receiver stalls, a finished result holds in the output register
//   and the block keeps taking requests; a request whose result would need the
//   output register waits until the register is taken.
// ----------------------------------------------------------------------------
module canonical_huffman_codec (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [chc_pkg::COUNT_W-1:0]    cfg_write_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [chc_pkg::OP_W-1:0]       operation,
  input  logic [chc_pkg::LEN_W-1:0]      length_index,
  input  logic [chc_pkg::CNT_VAL_W-1:0]  count_value,
  input  logic [chc_pkg::SYMBOL_W-1:0]   symbol_index,
  input  logic [chc_pkg::SYMBOL_W-1:0]   symbol_value,
  input  logic                           stream_bit,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           result_kind,
  output logic [chc_pkg::STATUS_W-1:0]   status,
  output logic [chc_pkg::SYMBOL_W-1:0]   decoded_symbol,
  output logic [chc_pkg::CODE_W-1:0]     code_bits,
  output logic [chc_pkg::LEN_W-1:0]      code_length
);

  import chc_pkg::*;

  // Control state
  state_t                 state, state_next;
  logic [COUNT_W-1:0]     symbol_count;
  logic [COUNT_W-1:0]     eff_count;
  logic [CODE_W-1:0]      pending_code;
  logic [LEN_IDX_W-1:0]   pending_length;
  logic [ENC_DEPTH-1:0]   enc_valid;

  // Per-length tables
  logic [CNT_VAL_W-1:0]   length_counts [MAX_CODE_LENGTH];
  logic [TAB_W-1:0]       first_code    [MAX_CODE_LENGTH];
  logic [TAB_W-1:0]       code_limit    [MAX_CODE_LENGTH];
  logic [OFFSET_W-1:0]    value_offset  [MAX_CODE_LENGTH];

  // Build walk
  logic [LEN_IDX_W-1:0]   bld_len;
  logic [TAB_W-1:0]       bld_code;
  logic [POS_W-1:0]       bld_pos;
  logic [CNT_VAL_W-1:0]   bld_k;
  logic                   bld_done;
  logic                   bld_room;
  logic                   bld_last;
  logic [OFFSET_W-1:0]    bld_vo;

  // Decode step
  logic [CODE_W-1:0]      dec_code;
  logic [LEN_IDX_W-1:0]   dec_lidx;
  logic [TAB_W-1:0]       dec_fc;
  logic [TAB_W-1:0]       dec_lim;
  logic [OFFSET_W-1:0]    dec_vo;
  logic [TAB_W-1:0]       dec_code_ext;
  logic [TAB_W:0]         dec_idx;
  logic                   dec_hit;
  logic                   dec_above;
  logic                   dec_in_list;
  logic                   dec_last;

  // Pending result
  src_t                   res_src;
  status_t                res_status;
  logic                   enc_hit;

  // Handshake and request decode
  op_t                    op;
  logic                   req_accept;
  logic                   out_free;
  logic [LEN_W-1:0]       cnt_idx;
  logic                   cnt_ok;
  logic                   sym_ok;

  // RAM ports
  logic                   sym_we, sym_re;
  logic [SYM_AW-1:0]      sym_raddr;
  logic [SYMBOL_W-1:0]    sym_rdata;
  logic                   enc_we, enc_re;
  logic [ENC_W-1:0]       enc_wdata;
  logic [ENC_W-1:0]       enc_rdata;

  assign op         = op_t'(operation);
  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !res_valid || !res_stall;
  assign eff_count  = (symbol_count > COUNT_W'(SYMBOL_CAPACITY)) ?
                      COUNT_W'(SYMBOL_CAPACITY) : symbol_count;

  assign cnt_idx = length_index - LEN_W'(1);
  assign cnt_ok  = (length_index != '0) && (int'(length_index) <= MAX_CODE_LENGTH);
  assign sym_ok  = int'(symbol_index) < SYMBOL_CAPACITY;

  // Build walk conditions
  assign bld_done = (bld_k == length_counts[bld_len]);
  assign bld_room = (bld_pos < POS_W'(eff_count));
  assign bld_last = (bld_len == LEN_IDX_W'(MAX_CODE_LENGTH - 1));
  assign bld_vo   = (bld_pos > POS_W'(OFFSET_MAX)) ? OFFSET_W'(OFFSET_MAX)
                                                   : OFFSET_W'(bld_pos);

  // Decode compare and list index
  assign dec_code_ext = TAB_W'(dec_code);
  assign dec_hit      = (dec_code_ext < dec_lim);
  assign dec_above    = (dec_code_ext >= dec_fc);
  assign dec_idx      = (TAB_W+1)'(dec_vo) + (TAB_W+1)'(dec_code_ext - dec_fc);
  assign dec_in_list  = (dec_idx < (TAB_W+1)'(eff_count)) &&
                        (dec_idx < (TAB_W+1)'(SYMBOL_CAPACITY));
  assign dec_last     = (dec_lidx == LEN_IDX_W'(MAX_CODE_LENGTH - 1));

  // Memory port control
  assign sym_we    = req_accept && (op == OP_LOAD_SYMBOL) && sym_ok;
  assign sym_re    = ((state == ST_BSYM) && !bld_done && bld_room) ||
                     ((state == ST_DCMP) && dec_hit && dec_above && dec_in_list);
  assign sym_raddr = (state == ST_BSYM) ? bld_pos[SYM_AW-1:0] : dec_idx[SYM_AW-1:0];
  assign enc_we    = (state == ST_BWR);
  assign enc_wdata = {bld_code[CODE_W-1:0], LEN_W'(bld_len) + LEN_W'(1)};
  assign enc_re    = req_accept && (op == OP_ENCODE);

  chc_ram #(
    .WIDTH (SYMBOL_W),
    .DEPTH (SYMBOL_CAPACITY)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (symbol_index[SYM_AW-1:0]),
    .wdata (symbol_value),
    .re    (sym_re),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  chc_ram #(
    .WIDTH (ENC_W),
    .DEPTH (ENC_DEPTH)
  ) u_enc_ram (
    .clk   (clk),
    .we    (enc_we),
    .waddr (sym_rdata[ENC_AW-1:0]),
    .wdata (enc_wdata),
    .re    (enc_re),
    .raddr (symbol_value[ENC_AW-1:0]),
    .rdata (enc_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_accept) begin
          case (op)
            OP_BUILD:      state_next = ST_BLEN;
            OP_DECODE_BIT: state_next = ST_DCMP;
            OP_END_STREAM: state_next = ST_EMIT;
            OP_ENCODE:     state_next = ST_EMIT;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_BLEN: state_next = ST_BSYM;
      ST_BSYM: begin
        if (bld_done) begin
          state_next = bld_last ? ST_IDLE : ST_BLEN;
        end else if (bld_room) begin
          state_next = ST_BWR;
        end
      end
      ST_BWR:  state_next = ST_BSYM;
      ST_DCMP: begin
        if (dec_hit || dec_last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers, tables and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count   <= '0;
      pending_code   <= '0;
      pending_length <= '0;
      enc_valid      <= '0;
      res_valid      <= 1'b0;
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        length_counts[i] <= '0;
        first_code[i]    <= '0;
        code_limit[i]    <= '0;
        value_offset[i]  <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        symbol_count <= cfg_write_data;
      end
      case (state)
        ST_IDLE: begin
          if (req_accept) begin
            case (op)
              OP_LOAD_COUNT: begin
                if (cnt_ok) begin
                  length_counts[cnt_idx[LEN_IDX_W-1:0]] <= count_value;
                end
              end
              OP_BUILD: begin
                enc_valid      <= '0;
                pending_code   <= '0;
                pending_length <= '0;
              end
              OP_END_STREAM: begin
                pending_code   <= '0;
                pending_length <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_BLEN: begin
          first_code[bld_len]   <= bld_code;
          value_offset[bld_len] <= bld_vo;
        end
        ST_BSYM: begin
          if (bld_done) begin
            code_limit[bld_len] <= bld_code;
          end
        end
        ST_BWR: begin
          enc_valid[sym_rdata[ENC_AW-1:0]] <= 1'b1;
        end
        ST_DCMP: begin
          // Clear on any result, else keep the bits and wait for more
          if (dec_hit || dec_last) begin
            pending_code   <= '0;
            pending_length <= '0;
          end else begin
            pending_code   <= dec_code;
            pending_length <= dec_lidx + LEN_IDX_W'(1);
          end
        end
        default: ;
      endcase
      // Output valid: load on emit, drop once taken
      if ((state == ST_EMIT) && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_accept) begin
          case (op)
            OP_BUILD: begin
              bld_len  <= '0;
              bld_code <= '0;
              bld_pos  <= '0;
            end
            OP_DECODE_BIT: begin
              dec_code <= {pending_code[CODE_W-2:0], stream_bit};
              dec_lidx <= pending_length;
              dec_fc   <= first_code[pending_length];
              dec_lim  <= code_limit[pending_length];
              dec_vo   <= value_offset[pending_length];
            end
            OP_END_STREAM: begin
              res_src    <= SRC_REG;
              res_status <= STATUS_END_DATA;
            end
            OP_ENCODE: begin
              res_src <= SRC_ENC;
              enc_hit <= enc_valid[symbol_value[ENC_AW-1:0]];
            end
            default: ;
          endcase
        end
      end
      ST_BLEN: begin
        bld_k <= '0;
      end
      ST_BSYM: begin
        // Close the length, or step past a code with no symbol to place
        if (bld_done) begin
          bld_code <= {bld_code[TAB_W-2:0], 1'b0};
          bld_len  <= bld_len + LEN_IDX_W'(1);
        end else if (!bld_room) begin
          bld_code <= bld_code + TAB_W'(1);
          bld_pos  <= bld_pos + POS_W'(1);
          bld_k    <= bld_k + CNT_VAL_W'(1);
        end
      end
      ST_BWR: begin
        bld_code <= bld_code + TAB_W'(1);
        bld_pos  <= bld_pos + POS_W'(1);
        bld_k    <= bld_k + CNT_VAL_W'(1);
      end
      ST_DCMP: begin
        if (dec_hit) begin
          res_src    <= (dec_above && dec_in_list) ? SRC_SYM : SRC_REG;
          res_status <= STATUS_BAD_INDEX;
        end else begin
          res_src    <= SRC_REG;
          res_status <= STATUS_NO_CODE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          case (res_src)
            SRC_SYM: begin
              result_kind    <= KIND_DECODE;
              status         <= STATUS_OK;
              decoded_symbol <= sym_rdata;
              code_bits      <= '0;
              code_length    <= '0;
            end
            SRC_ENC: begin
              result_kind    <= KIND_ENCODE;
              status         <= enc_hit ? STATUS_OK : STATUS_NOT_FOUND;
              decoded_symbol <= '0;
              code_bits      <= enc_hit ? enc_rdata[ENC_W-1:LEN_W] : '0;
              code_length    <= enc_hit ? enc_rdata[LEN_W-1:0] : '0;
            end
            default: begin
              result_kind    <= KIND_DECODE;
              status         <= res_status;
              decoded_symbol <= '0;
              code_bits      <= '0;
              code_length    <= '0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // Decode results never carry encode payload
  a_dec_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (result_kind == KIND_DECODE)) |->
      ((code_bits == '0) && (code_length == '0)))
    else $error("decode result carries code payload");

  // A found encode result always has a nonzero length
  a_enc_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (result_kind == KIND_ENCODE) && (status == STATUS_OK)) |->
      (code_length != '0))
    else $error("encode hit with zero length");

  // The longest code step always clears the pending bits
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DCMP) && dec_last) |=> (pending_length == '0))
    else $error("pending bits survive the longest length");

  // Symbols are placed only from inside the loaded list
  a_build_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BWR) |-> (bld_pos < POS_W'(eff_count)))
    else $error("build placed a symbol past the list");
`endif

endmodule

[sim/canonical_huffman_codec_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// canonical_huffman_codec_tb: self-checking bench for the Huffman codec
// Feeds table loads, builds, decode bits, end-of-stream markers and encode
// lookups, keeps its own copy of the code tables to predict every result, and
// compares each result field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module canonical_huffman_codec_tb;
  import chc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int SETTLE_CYCLES = 5000;      // longest build plus margin
  localparam int LONG_HOLD    = 600;
  localparam int PHASE_ITEMS  = 160;
  localparam int TIMEOUT_NS   = 30_000_000;

  // Operation codes with no function in the block
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [LEN_W-1:0]     len_idx;
    logic [CNT_VAL_W-1:0] count;
    logic [SYMBOL_W-1:0]  sym_idx;
    logic [SYMBOL_W-1:0]  sym_val;
    logic                 sbit;
  } req_item_t;

  typedef struct packed {
    logic                 kind;
    logic [STATUS_W-1:0]  status;
    logic [SYMBOL_W-1:0]  symbol;
    logic [CODE_W-1:0]    code;
    logic [LEN_W-1:0]     length;
  } res_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [COUNT_W-1:0]   cfg_write_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [OP_W-1:0]      operation = '0;
  logic [LEN_W-1:0]     length_index = '0;
  logic [CNT_VAL_W-1:0] count_value = '0;
  logic [SYMBOL_W-1:0]  symbol_index = '0;
  logic [SYMBOL_W-1:0]  symbol_value = '0;
  logic                 stream_bit = 1'b0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic                 result_kind;
  logic [STATUS_W-1:0]  status;
  logic [SYMBOL_W-1:0]  decoded_symbol;
  logic [CODE_W-1:0]    code_bits;
  logic [LEN_W-1:0]     code_length;

  canonical_huffman_codec DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .length_index  (length_index),
    .count_value   (count_value),
    .symbol_index  (symbol_index),
    .symbol_value  (symbol_value),
    .stream_bit    (stream_bit),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .result_kind   (result_kind),
    .status        (status),
    .decoded_symbol(decoded_symbol),
    .code_bits     (code_bits),
    .code_length   (code_length)
  );

  always #CLK_HALF clk = ~clk;

  // Table copy used to predict results
  bit [CNT_VAL_W-1:0] len_count  [MAX_CODE_LENGTH];
  bit [SYMBOL_W-1:0]  sym_list   [SYMBOL_CAPACITY];
  bit [TAB_W-1:0]     first_tab  [MAX_CODE_LENGTH];
  bit [TAB_W-1:0]     limit_tab  [MAX_CODE_LENGTH];
  bit [OFFSET_W-1:0]  offset_tab [MAX_CODE_LENGTH];
  bit [CODE_W-1:0]    enc_bits   [ENC_DEPTH];
  bit [LEN_W-1:0]     enc_len    [ENC_DEPTH];
  bit [CODE_W-1:0]    acc_code;
  bit [LEN_W-1:0]     acc_len;
  bit [COUNT_W-1:0]   list_size;

  req_item_t requests_todo[$];
  res_item_t results_due[$];
  req_item_t cur_req;
  int        fail_count = 0;
  int        queued_count = 0;

  // Stimulus side view of what has been loaded and built
  int             gen_loaded [MAX_CODE_LENGTH];
  int             gen_built  [MAX_CODE_LENGTH];
  int             gen_total = 0;
  logic [7:0]     gen_syms   [SYMBOL_CAPACITY];

  // Handshake bookkeeping
  bit req_taken = 1'b0;
  bit req_busy = 1'b0;
  bit res_taken = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int tx_gap = 0;
  int rx_wait = 0;
  int rx_hold = 0;

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Apply one accepted request to the table copy; queue its result, if any
  task automatic predict_codec_result(input req_item_t r);
    res_item_t   e;
    logic [23:0] code_acc;
    int unsigned pos, lim, idx;
    bit          emit;
    e = '0;
    emit = 1'b0;
    lim = (list_size > SYMBOL_CAPACITY) ? SYMBOL_CAPACITY : list_size;
    case (r.op)
      OP_LOAD_COUNT: begin
        if (r.len_idx >= 1 && r.len_idx <= MAX_CODE_LENGTH) len_count[r.len_idx - 1] = r.count;
      end
      OP_LOAD_SYMBOL: begin
        sym_list[r.sym_idx] = r.sym_val;
      end
      OP_BUILD: begin
        code_acc = '0;
        pos = 0;
        for (int s = 0; s < ENC_DEPTH; s++) begin
          enc_bits[s] = '0;
          enc_len[s] = '0;
        end
        // Walk the lengths and hand out canonical codes
        for (int l = 1; l <= MAX_CODE_LENGTH; l++) begin
          first_tab[l - 1] = code_acc;
          offset_tab[l - 1] = OFFSET_W'((pos > OFFSET_MAX) ? OFFSET_MAX : pos);
          for (int k = 0; k < len_count[l - 1]; k++) begin
            if (pos < lim) begin
              enc_bits[sym_list[pos]] = code_acc[CODE_W-1:0];
              enc_len[sym_list[pos]] = LEN_W'(l);
            end
            code_acc = code_acc + 24'd1;
            pos++;
          end
          limit_tab[l - 1] = code_acc;
          code_acc = code_acc << 1;
        end
        acc_code = '0;
        acc_len = '0;
      end
      OP_DECODE_BIT: begin
        acc_code = {acc_code[CODE_W-2:0], r.sbit};
        acc_len = acc_len + LEN_W'(1);
        e.kind = KIND_DECODE;
        if (acc_code < limit_tab[acc_len - 1]) begin
          emit = 1'b1;
          e.status = STATUS_BAD_INDEX;
          if (acc_code >= first_tab[acc_len - 1]) begin
            idx = offset_tab[acc_len - 1] + (acc_code - first_tab[acc_len - 1]);
            if (idx < lim) begin
              e.status = STATUS_OK;
              e.symbol = sym_list[idx];
            end
          end
        end else if (acc_len >= MAX_CODE_LENGTH) begin
          emit = 1'b1;
          e.status = STATUS_NO_CODE;
        end
        if (emit) begin
          acc_code = '0;
          acc_len = '0;
        end
      end
      OP_END_STREAM: begin
        acc_code = '0;
        acc_len = '0;
        emit = 1'b1;
        e.kind = KIND_DECODE;
        e.status = STATUS_END_DATA;
      end
      OP_ENCODE: begin
        emit = 1'b1;
        e.kind = KIND_ENCODE;
        if (enc_len[r.sym_val] == 0) begin
          e.status = STATUS_NOT_FOUND;
        end else begin
          e.code = enc_bits[r.sym_val];
          e.length = enc_len[r.sym_val];
        end
      end
      default: ;
    endcase
    if (emit) results_due.push_back(e);
  endtask

  // Queue a request and track what the tables will hold once it is taken
  task automatic push_req(input logic [OP_W-1:0] op, input int unsigned li,
                          input int unsigned cv, input int unsigned si,
                          input int unsigned sv, input int unsigned b);
    req_item_t r;
    r = '{op: op, len_idx: LEN_W'(li), count: CNT_VAL_W'(cv),
          sym_idx: SYMBOL_W'(si), sym_val: SYMBOL_W'(sv), sbit: 1'(b)};
    requests_todo.push_back(r);
    if (op <= OP_ENCODE) queued_count++;
    if (op == OP_LOAD_COUNT && r.len_idx >= 1 && r.len_idx <= MAX_CODE_LENGTH)
      gen_loaded[r.len_idx - 1] = r.count;
    if (op == OP_LOAD_SYMBOL) gen_syms[r.sym_idx] = r.sym_val;
    if (op == OP_BUILD) begin
      gen_total = 0;
      for (int l = 0; l < MAX_CODE_LENGTH; l++) begin
        gen_built[l] = gen_loaded[l];
        gen_total += gen_loaded[l];
      end
    end
  endtask

  task automatic push_bit(input int unsigned b);
    push_req(OP_DECODE_BIT, $urandom, $urandom, $urandom, $urandom, b);
  endtask

  task automatic push_op(input logic [OP_W-1:0] op, input int unsigned sv);
    push_req(op, $urandom, $urandom, $urandom, sv, $urandom);
  endtask

  // Send the first keep bits of the code at list position p, MSB first
  task automatic push_codeword(input int p, input int keep);
    int base, code, clen, cval;
    base = 0;
    code = 0;
    clen = 0;
    cval = 0;
    for (int l = 1; l <= MAX_CODE_LENGTH; l++) begin
      if (clen == 0 && p < base + gen_built[l - 1]) begin
        clen = l;
        cval = code + (p - base);
      end
      base += gen_built[l - 1];
      code = ((code + gen_built[l - 1]) << 1) & 24'hFFFFFF;
    end
    for (int i = 0; i < clen && i < keep; i++) push_bit(cval[clen - 1 - i]);
  endtask

  // Load a fresh set of length counts in random order, then build
  task automatic load_table(input bit proper);
    int avail, room, hi, c, j, t;
    int order [MAX_CODE_LENGTH];
    int cnt   [MAX_CODE_LENGTH];
    avail = 2;
    room = $urandom_range(1, SYMBOL_CAPACITY);
    for (int l = 0; l < MAX_CODE_LENGTH; l++) begin
      if (proper) begin
        // keep the code prefix-free and within the list
        hi = (avail < room) ? avail : room;
        if (hi > 255) hi = 255;
        c = $urandom_range(0, (hi + 1) / 2);
        room -= c;
        avail = (avail - c) * 2;
        if (avail > 65536) avail = 65536;
      end else begin
        c = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
      end
      cnt[l] = c;
      order[l] = l;
    end
    for (int i = MAX_CODE_LENGTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i])
      push_req(OP_LOAD_COUNT, order[i] + 1, cnt[order[i]], $urandom, $urandom, $urandom);
    push_op(OP_BUILD, $urandom);
  endtask

  // One random sequence, mostly well-formed code streams and lookups
  task automatic random_sequence();
    int pick, span;
    pick = $urandom_range(0, 99);
    span = (gen_total > SYMBOL_CAPACITY) ? SYMBOL_CAPACITY : gen_total;
    if (pick < 45 && gen_total != 0) begin
      repeat ($urandom_range(1, 4)) push_codeword($urandom_range(0, gen_total - 1), 16);
      if ($urandom_range(0, 3) == 0) push_op(OP_END_STREAM, $urandom);
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 6)) begin
        if (span != 0 && $urandom_range(0, 1))
          push_op(OP_ENCODE, gen_syms[$urandom_range(0, span - 1)]);
        else
          push_op(OP_ENCODE, $urandom);
      end
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 20)) push_bit($urandom);
      push_op(OP_END_STREAM, $urandom);
    end else if (pick < 82 && gen_total != 0) begin
      // cut a code short
      push_codeword($urandom_range(0, gen_total - 1), $urandom_range(1, 15));
      push_op(OP_END_STREAM, $urandom);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 4))
        push_req(OP_LOAD_SYMBOL, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 92) begin
      load_table(1'b1);
    end else if (pick == 92) begin
      load_table(1'b0);
    end else if (pick < 96) begin
      push_op(OP_END_STREAM, $urandom);
    end else if (pick < 98) begin
      push_op($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, $urandom);
    end else begin
      push_req(OP_LOAD_COUNT, $urandom_range(0, 1) ? 0 : $urandom_range(17, 31),
               $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Hold until every request is taken and answered, then let a build finish
  task automatic drain_and_settle();
    while (requests_todo.size() != 0 || req_busy || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_symbol_count(input int unsigned v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= COUNT_W'(v);
    @(posedge clk);
    list_size = COUNT_W'(v);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Note each accepted request and predict its result
  always @(posedge clk) begin
    req_taken = !rst && req_valid && !req_stall;
    if (req_taken) predict_codec_result(cur_req);
  end

  // Present requests with random gaps between them
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) req_busy = 1'b0;
      if (!req_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (requests_todo.size() != 0) begin
          cur_req = requests_todo.pop_front();
          req_busy = 1'b1;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_gap = draw_wait(tx_calm);
          operation <= cur_req.op;
          length_index <= cur_req.len_idx;
          count_value <= cur_req.count;
          symbol_index <= cur_req.sym_idx;
          symbol_value <= cur_req.sym_val;
          stream_bit <= cur_req.sbit;
        end
      end
      req_valid <= req_busy;
    end
  end

  // Stall the result side at random, or for a long hold when asked
  always @(negedge clk) begin
    if (res_taken) begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      rx_wait = draw_wait(rx_calm);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      res_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    res_item_t want;
    res_taken = !rst && res_valid === 1'b1 && res_stall === 1'b0;
    if (res_taken) begin
      if (results_due.size() == 0) begin
        $error("result with none due: kind %0d status %0d", result_kind, status);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(result_kind));
        check_field("status", 16'(want.status), 16'(status));
        check_field("decoded_symbol", 16'(want.symbol), 16'(decoded_symbol));
        check_field("code_bits", want.code, code_bits);
        check_field("code_length", 16'(want.length), 16'(code_length));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("canonical_huffman_codec_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int dc_luma [MAX_CODE_LENGTH];
    int phase_counts [6];
    int start;
    dc_luma = '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
    phase_counts = '{256, 511, 1, 0, 257, 0};
    phase_counts[5] = $urandom_range(2, 255);
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Empty tables: lookup misses, spare opcodes, bad count indexes
    push_op(OP_ENCODE, 8'h00);
    push_op(OP_SPARE_A, 8'hFF);
    push_op(OP_SPARE_B, 8'h00);
    push_req(OP_LOAD_COUNT, 5'd0, 8'hFF, 8'h00, 8'h00, 1'b0);
    push_req(OP_LOAD_COUNT, 5'd17, 8'hAA, 8'hFF, 8'hFF, 1'b1);
    push_req(OP_LOAD_COUNT, 5'd31, 8'hFF, 8'h55, 8'hAA, 1'b0);
    // no code within sixteen bits, then end of stream
    for (int i = 0; i < MAX_CODE_LENGTH; i++) push_bit(i[0]);
    push_op(OP_END_STREAM, 8'h00);

    // Fill the whole symbol list so no entry is read before it is written
    for (int s = 0; s < SYMBOL_CAPACITY; s++)
      push_req(OP_LOAD_SYMBOL, $urandom, $urandom, s, $urandom, $urandom);
    drain_and_settle();
    set_symbol_count(SYMBOL_CAPACITY);

    // Standard luminance DC table: lookups, codes, cut codes
    for (int l = 0; l < MAX_CODE_LENGTH; l++)
      push_req(OP_LOAD_COUNT, l + 1, dc_luma[l], $urandom, $urandom, $urandom);
    push_op(OP_BUILD, $urandom);
    push_op(OP_ENCODE, gen_syms[0]);
    push_op(OP_ENCODE, gen_syms[11]);
    push_codeword(0, 16);
    push_codeword(11, 16);
    push_codeword(5, 16);
    push_codeword(11, 4);
    push_op(OP_END_STREAM, $urandom);
    repeat (MAX_CODE_LENGTH) push_bit(1'b1);
    // a build drops the bits gathered so far
    push_bit(1'b1);
    push_bit(1'b1);
    push_op(OP_BUILD, $urandom);
    push_codeword(2, 16);
    drain_and_settle();

    // Random phases, one per symbol count setting
    foreach (phase_counts[p]) begin
      set_symbol_count(phase_counts[p]);
      start = queued_count;
      if (phase_counts[p] == 511) load_table(1'b0);
      load_table(1'b1);
      while (queued_count - start < PHASE_ITEMS) random_sequence();
      if (p == 0) begin
        // hold off the result side while requests keep coming
        @(posedge clk);
        rx_hold = LONG_HOLD;
      end
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("canonical_huffman_codec_tb OK");
    end else begin
      $display("canonical_huffman_codec_tb NOT OK");
    end
    $finish;
  end

endmodule
